// ===== rtl/btu_pkg.sv =====
// Shared widths, opcodes, slot record and field packing for the breakpoint trigger unit.
package btu_pkg;

    localparam int PC_W     = 32;
    localparam int TYPE_W   = 7;
    localparam int REG_W    = 5;
    localparam int FUNCT_W  = 10;
    localparam int IMM_W    = 32;
    localparam int MATCH_W  = 57;
    localparam int FLAGS_W  = 4;
    localparam int OPCODE_W = 2;
    localparam int IDX_W    = 3;
    localparam int TEST_W   = 3;

    // Flag bit positions in an add beat
    localparam int FLAG_SIGNED     = 2;
    localparam int FLAG_SINGLE_USE = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CHECK = 2'd0,
        OP_POLL  = 2'd1,
        OP_ADD   = 2'd2
    } t_opcode;

    // Low two bits of the stored pc test
    typedef enum logic [1:0] {
        PC_NONE = 2'd0,
        PC_GT   = 2'd1,
        PC_LT   = 2'd2,
        PC_EQ   = 2'd3
    } t_pc_cmp;

    typedef struct packed {
        logic               single_use;
        logic [TYPE_W-1:0]  match_type;
        logic [MATCH_W-1:0] match_value;
        logic [MATCH_W-1:0] match_mask;
        logic [TEST_W-1:0]  pc_test;
        logic [PC_W-1:0]    pc_value;
    } t_slot_cfg;

    // Pack rd, rs1, rs2, funct and imm into one match word
    function automatic logic [MATCH_W-1:0] pack_fields(
        input logic [REG_W-1:0]   rd,
        input logic [REG_W-1:0]   rs1,
        input logic [REG_W-1:0]   rs2,
        input logic [FUNCT_W-1:0] funct,
        input logic [IMM_W-1:0]   imm
    );
        return {imm, funct, rs2, rs1, rd};
    endfunction

endpackage

// ===== rtl/btu_if.sv =====
// Command and response channel interfaces of the breakpoint trigger unit.
interface btu_cmd_if import btu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PC_W-1:0]     pc;
    logic [TYPE_W-1:0]   insn_type;
    logic [REG_W-1:0]    rd_field;
    logic [REG_W-1:0]    rs1_field;
    logic [REG_W-1:0]    rs2_field;
    logic [FUNCT_W-1:0]  funct_field;
    logic [IMM_W-1:0]    imm_field;
    logic [MATCH_W-1:0]  match_mask;
    logic [FLAGS_W-1:0]  slot_flags;

    modport source (
        output valid, opcode, pc, insn_type, rd_field, rs1_field, rs2_field,
               funct_field, imm_field, match_mask, slot_flags,
        input  ready
    );
    modport sink (
        input  valid, opcode, pc, insn_type, rd_field, rs1_field, rs2_field,
               funct_field, imm_field, match_mask, slot_flags,
        output ready
    );
endinterface

interface btu_rsp_if import btu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             success;
    logic [IDX_W-1:0] slot_index;
    logic             slot_one_shot;

    modport source (output valid, success, slot_index, slot_one_shot, input ready);
    modport sink   (input  valid, success, slot_index, slot_one_shot, output ready);
endinterface

// ===== rtl/btu_slot_match.sv =====
// Trigger test of one breakpoint slot against a checked instruction.
module btu_slot_match import btu_pkg::*; #(
    parameter int NO_TYPE_CODE = 0
) (
    input  t_slot_cfg          i_cfg,
    input  logic [PC_W-1:0]    i_pc,
    input  logic [TYPE_W-1:0]  i_type,
    input  logic [MATCH_W-1:0] i_fields,
    output logic               o_hit
);

    localparam logic [TYPE_W-1:0] NoType = TYPE_W'(NO_TYPE_CODE);

    logic            ins_en;
    logic            pc_en;
    logic            ins_ok;
    logic            pc_ok;
    logic [PC_W-1:0] cmp_a;
    logic [PC_W-1:0] cmp_b;
    t_pc_cmp         cmp_op;

    // Instruction test: type equal and masked fields equal
    assign ins_en = (i_cfg.match_type != NoType);
    assign ins_ok = (i_cfg.match_type == i_type) &&
                    (((i_cfg.match_value ^ i_fields) & i_cfg.match_mask) == '0);

    // Pc test: flip sign bits for a signed compare
    assign cmp_op = t_pc_cmp'(i_cfg.pc_test[1:0]);
    assign pc_en  = (cmp_op != PC_NONE);
    assign cmp_a  = i_pc ^ {i_cfg.pc_test[FLAG_SIGNED], {(PC_W-1){1'b0}}};
    assign cmp_b  = i_cfg.pc_value ^ {i_cfg.pc_test[FLAG_SIGNED], {(PC_W-1){1'b0}}};

    always_comb begin
        unique case (cmp_op)
            PC_GT:   pc_ok = (cmp_a > cmp_b);
            PC_LT:   pc_ok = (cmp_a < cmp_b);
            PC_EQ:   pc_ok = (cmp_a == cmp_b);
            default: pc_ok = 1'b0;
        endcase
    end

    // Both enabled tests must pass; no test means no trigger
    assign o_hit = (ins_en || pc_en) && (!ins_en || ins_ok) && (!pc_en || pc_ok);

endmodule

// ===== rtl/breakpoint_trigger_unit.sv =====
// Breakpoint trigger unit: slot table, check/poll/add processing and response register.
//
//   channel  dir  handshake      payload
//   i_cmd    in   valid/ready    opcode, pc, insn_type, fields, match_mask, slot_flags
//   o_rsp    out  valid/ready    success, slot_index, slot_one_shot
//
// Each command beat is registered in the input register, processed against the
// slot table once the response register is free or draining, and its response
// registered in the response register: one beat per cycle sustained while the
// response side is ready, set by the single slot-compare stage.
// Reset clears all slots to inactive and untriggered; slot contents load on add.
// A stalled response holds the processing stage; a command is still taken while
// the input register is empty or draining.
module breakpoint_trigger_unit import btu_pkg::*; #(
    parameter int SLOT_COUNT   = 8,
    parameter int NO_TYPE_CODE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    btu_cmd_if.sink   i_cmd,
    btu_rsp_if.source o_rsp
);

    // Input stage
    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_op;
    logic [PC_W-1:0]     r_pc;
    logic [TYPE_W-1:0]   r_type;
    logic [MATCH_W-1:0]  r_fields;
    logic [MATCH_W-1:0]  r_mask;
    logic [FLAGS_W-1:0]  r_flags;

    // Slot table
    logic [SLOT_COUNT-1:0] r_active;
    logic [SLOT_COUNT-1:0] r_trig;
    t_slot_cfg             r_cfg [SLOT_COUNT];

    // Response stage
    logic             r_out_vld;
    logic             r_success;
    logic [IDX_W-1:0] r_slot_index;
    logic             r_used_up;

    logic                  go;
    logic                  in_take;
    logic [SLOT_COUNT-1:0] hit;
    logic [SLOT_COUNT-1:0] single_use;
    logic [SLOT_COUNT-1:0] poll_sel;
    logic [SLOT_COUNT-1:0] add_sel;
    logic [IDX_W-1:0]      poll_idx;
    logic [IDX_W-1:0]      add_idx;
    logic                  n_success;
    logic [IDX_W-1:0]      n_slot_index;
    logic                  n_used_up;
    t_slot_cfg             add_cfg;

    // Handshake: process when the response register is free or draining
    assign go      = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign in_take = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_in_vld || go;

    // Capture the command beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_cmd.opcode;
            r_pc     <= i_cmd.pc;
            r_type   <= i_cmd.insn_type;
            r_fields <= pack_fields(i_cmd.rd_field, i_cmd.rs1_field, i_cmd.rs2_field,
                                    i_cmd.funct_field, i_cmd.imm_field);
            r_mask   <= i_cmd.match_mask;
            r_flags  <= i_cmd.slot_flags;
        end
    end

    // Per-slot trigger tests
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        btu_slot_match #(
            .NO_TYPE_CODE (NO_TYPE_CODE)
        ) u_match (
            .i_cfg    (r_cfg[g]),
            .i_pc     (r_pc),
            .i_type   (r_type),
            .i_fields (r_fields),
            .o_hit    (hit[g])
        );
        assign single_use[g] = r_cfg[g].single_use;
    end

    // Pick lowest triggered slot for poll and lowest free slot for add
    always_comb begin
        poll_sel = '0;
        poll_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_active[i] && r_trig[i]) begin
                poll_sel    = '0;
                poll_sel[i] = 1'b1;
                poll_idx    = IDX_W'(i);
            end
        end
    end

    always_comb begin
        add_sel = '0;
        add_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                add_sel    = '0;
                add_sel[i] = 1'b1;
                add_idx    = IDX_W'(i);
            end
        end
    end

    // Slot record built from an add beat
    always_comb begin
        add_cfg.single_use  = r_flags[FLAG_SINGLE_USE];
        add_cfg.match_type  = r_type;
        add_cfg.match_value = r_fields;
        add_cfg.match_mask  = r_mask;
        add_cfg.pc_test     = r_flags[TEST_W-1:0];
        add_cfg.pc_value    = r_pc;
    end

    // Response for the current beat
    always_comb begin
        n_success    = 1'b0;
        n_slot_index = '0;
        n_used_up    = 1'b0;
        unique case (t_opcode'(r_op))
            OP_CHECK: begin
                n_success = 1'b1;
            end
            OP_POLL: begin
                n_success    = |poll_sel;
                n_slot_index = poll_idx;
                n_used_up    = |(poll_sel & single_use);
            end
            OP_ADD: begin
                n_success    = |add_sel;
                n_slot_index = add_idx;
            end
            default: begin
                n_success = 1'b0;
            end
        endcase
    end

    // Update slot status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_trig   <= '0;
        end else if (go) begin
            unique case (t_opcode'(r_op))
                OP_CHECK: begin
                    r_trig <= r_active & ~r_trig & hit;
                end
                OP_POLL: begin
                    r_active <= r_active & ~(poll_sel & single_use);
                end
                OP_ADD: begin
                    r_active <= r_active | add_sel;
                    r_trig   <= r_trig & ~add_sel;
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    // Load slot contents on add
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (go && (t_opcode'(r_op) == OP_ADD) && add_sel[i]) begin
                r_cfg[i] <= add_cfg;
            end
        end
    end

    // Hold the response beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (go) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_success    <= n_success;
            r_slot_index <= n_slot_index;
            r_used_up    <= n_used_up;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.success       = r_success;
    assign o_rsp.slot_index    = r_slot_index;
    assign o_rsp.slot_one_shot = r_used_up;

endmodule

// ===== tb/tb_breakpoint_trigger_unit.sv =====
// Self-checking testbench for the breakpoint trigger unit: directed rows, then random beats.
module tb_breakpoint_trigger_unit;
    import btu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                SLOTS          = 8;
    localparam logic [TYPE_W-1:0] NO_TYPE        = 7'd0;
    localparam logic [OPCODE_W-1:0] OP_RSVD      = 2'd3;
    localparam int                RANDOM_BEATS   = 1426;
    localparam int                HOLD_CYCLES    = 400;
    localparam int                HOLD_AFTER     = 200;
    localparam int                DRAIN_CYCLES   = 8;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PC_W-1:0]     pc;
        logic [TYPE_W-1:0]   insn_type;
        logic [REG_W-1:0]    rd;
        logic [REG_W-1:0]    rs1;
        logic [REG_W-1:0]    rs2;
        logic [FUNCT_W-1:0]  funct;
        logic [IMM_W-1:0]    imm;
        logic [MATCH_W-1:0]  mask;
        logic [FLAGS_W-1:0]  flags;
    } bp_beat_t;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] slot_index;
        logic             used_up;
    } bp_rsp_t;

    // One directed row: the beat, whether a fixed response is given, and that response
    typedef struct packed {
        bp_beat_t beat;
        logic     fixed;
        bp_rsp_t  rsp;
    } bp_row_t;

    logic i_clk;
    logic i_rst_n;

    btu_cmd_if cmd_bus ();
    btu_rsp_if rsp_bus ();

    breakpoint_trigger_unit #(
        .SLOT_COUNT   (SLOTS),
        .NO_TYPE_CODE (int'(NO_TYPE))
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the slot table
    logic      slot_on  [SLOTS];
    logic      slot_hit [SLOTS];
    t_slot_cfg slot_cfg [SLOTS];

    bp_rsp_t   rsp_due_q[$];
    bp_row_t   dir_rows[$];
    bp_rsp_t   got_rsp;
    bp_rsp_t   want_rsp;
    int        fail_count;
    int        rsp_seen;
    int        burst_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset, held low at start and then released
    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Signed or unsigned pc comparison of one slot
    function automatic logic pc_hit(input logic [TEST_W-1:0] test,
                                    input logic [PC_W-1:0] pc,
                                    input logic [PC_W-1:0] limit);
        case (t_pc_cmp'(test[1:0]))
            PC_GT:   return test[FLAG_SIGNED] ? ($signed(pc) > $signed(limit)) : (pc > limit);
            PC_LT:   return test[FLAG_SIGNED] ? ($signed(pc) < $signed(limit)) : (pc < limit);
            PC_EQ:   return pc == limit;
            default: return 1'b0;
        endcase
    endfunction

    // Apply one accepted beat to the shadow table and return its response
    function automatic bp_rsp_t table_apply(input bp_beat_t b);
        bp_rsp_t            r;
        logic [MATCH_W-1:0] word;
        logic               ins_en;
        logic               pc_en;
        logic               hit;
        logic               done;
        int                 i;
        r    = '0;
        word = {b.imm, b.funct, b.rs2, b.rs1, b.rd};
        done = 1'b0;
        case (b.opcode)
            OP_CHECK: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_on[i]) begin
                        if (slot_hit[i]) begin
                            slot_hit[i] = 1'b0;
                        end else begin
                            ins_en = slot_cfg[i].match_type != NO_TYPE;
                            pc_en  = t_pc_cmp'(slot_cfg[i].pc_test[1:0]) != PC_NONE;
                            hit    = ins_en || pc_en;
                            if (ins_en)
                                hit = hit && (slot_cfg[i].match_type == b.insn_type)
                                    && (((slot_cfg[i].match_value ^ word)
                                         & slot_cfg[i].match_mask) == '0);
                            if (pc_en)
                                hit = hit && pc_hit(slot_cfg[i].pc_test, b.pc,
                                                    slot_cfg[i].pc_value);
                            slot_hit[i] = hit;
                        end
                    end
                end
                r.success = 1'b1;
            end
            OP_POLL: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!done && slot_on[i] && slot_hit[i]) begin
                        done         = 1'b1;
                        r.success    = 1'b1;
                        r.slot_index = i[IDX_W-1:0];
                        if (slot_cfg[i].single_use) begin
                            slot_on[i] = 1'b0;
                            r.used_up  = 1'b1;
                        end
                    end
                end
            end
            OP_ADD: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!done && !slot_on[i]) begin
                        done                       = 1'b1;
                        slot_on[i]                 = 1'b1;
                        slot_hit[i]                = 1'b0;
                        slot_cfg[i].single_use     = b.flags[FLAG_SINGLE_USE];
                        slot_cfg[i].match_type     = b.insn_type;
                        slot_cfg[i].match_value    = word;
                        slot_cfg[i].match_mask     = b.mask;
                        slot_cfg[i].pc_test        = b.flags[TEST_W-1:0];
                        slot_cfg[i].pc_value       = b.pc;
                        r.success                  = 1'b1;
                        r.slot_index               = i[IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bp_beat_t beat(input logic [OPCODE_W-1:0] op,
                                      input logic [PC_W-1:0] pc,
                                      input logic [TYPE_W-1:0] ty,
                                      input logic [REG_W-1:0] rd, rs1, rs2,
                                      input logic [FUNCT_W-1:0] fn,
                                      input logic [IMM_W-1:0] imm,
                                      input logic [MATCH_W-1:0] mask,
                                      input logic [FLAGS_W-1:0] flags);
        return {op, pc, ty, rd, rs1, rs2, fn, imm, mask, flags};
    endfunction

    // Random beat, biased toward matches against the live slots
    function automatic bp_beat_t random_beat();
        bp_beat_t           b;
        logic [MATCH_W-1:0] word;
        int                 pick;
        int                 k;
        int                 bit_pos;
        int                 reusable;
        b    = '0;
        b.pc = $urandom;
        word = MATCH_W'({$urandom, $urandom});
        b.insn_type = ($urandom_range(0, 9) < 7) ? TYPE_W'($urandom_range(0, 3))
                                                 : TYPE_W'($urandom);
        b.mask  = MATCH_W'({$urandom, $urandom});
        b.flags = FLAGS_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            b.opcode = OP_CHECK;
            if ($urandom_range(0, 99) < 60) begin
                k = $urandom_range(0, SLOTS - 1);
                if (slot_on[k]) begin
                    b.insn_type = slot_cfg[k].match_type;
                    word = (slot_cfg[k].match_value & slot_cfg[k].match_mask)
                         | (word & ~slot_cfg[k].match_mask);
                    if ($urandom_range(0, 4) == 0) begin
                        bit_pos = $urandom_range(0, MATCH_W - 1);
                        word[bit_pos] = ~word[bit_pos];
                    end
                    b.pc = slot_cfg[k].pc_value;
                end
                if ($urandom_range(0, 1) == 0)
                    b.pc = b.pc + PC_W'($urandom_range(0, 2)) - 32'd1;
            end
        end else if (pick < 80) begin
            b.opcode = OP_POLL;
        end else if (pick < 96) begin
            b.opcode = OP_ADD;
            case ($urandom_range(0, 9))
                0, 1, 2: b.insn_type = NO_TYPE;
                3:       b.insn_type = TYPE_W'($urandom);
                default: b.insn_type = TYPE_W'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: b.mask = '0;
                3, 4, 5: b.mask = (MATCH_W'(1) << $urandom_range(0, MATCH_W - 1))
                                | (MATCH_W'(1) << $urandom_range(0, MATCH_W - 1));
                6, 7:    b.mask = MATCH_W'({$urandom, $urandom});
                default: b.mask = '1;
            endcase
            case ($urandom_range(0, 7))
                0:       b.pc = 32'h0000_0000;
                1:       b.pc = 32'h7FFF_FFFF;
                2:       b.pc = 32'h8000_0000;
                3:       b.pc = 32'hFFFF_FFFF;
                default: b.pc = $urandom;
            endcase
            // Keep most slots one-shot so polls keep freeing the table
            reusable = 0;
            for (k = 0; k < SLOTS; k++)
                if (slot_on[k] && !slot_cfg[k].single_use)
                    reusable++;
            if (reusable >= 3)
                b.flags[FLAG_SINGLE_USE] = 1'b1;
        end else begin
            b.opcode = OP_RSVD;
        end
        {b.imm, b.funct, b.rs2, b.rs1, b.rd} = word;
        return b;
    endfunction

    // Offer one beat in bursts with random gaps, then log its response
    task automatic offer(input bp_beat_t b, input logic fixed, input bp_rsp_t typed);
        int      gap;
        bp_rsp_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.opcode      <= b.opcode;
        cmd_bus.pc          <= b.pc;
        cmd_bus.insn_type   <= b.insn_type;
        cmd_bus.rd_field    <= b.rd;
        cmd_bus.rs1_field   <= b.rs1;
        cmd_bus.rs2_field   <= b.rs2;
        cmd_bus.funct_field <= b.funct;
        cmd_bus.imm_field   <= b.imm;
        cmd_bus.match_mask  <= b.mask;
        cmd_bus.slot_flags  <= b.flags;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predicted = table_apply(b);
        rsp_due_q.push_back(fixed ? typed : predicted);
        burst_left--;
    endtask

    // Stimulus: directed rows, random beats, drain, verdict
    initial begin
        int n;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.opcode      <= OP_CHECK;
        cmd_bus.pc          <= '0;
        cmd_bus.insn_type   <= '0;
        cmd_bus.rd_field    <= '0;
        cmd_bus.rs1_field   <= '0;
        cmd_bus.rs2_field   <= '0;
        cmd_bus.funct_field <= '0;
        cmd_bus.imm_field   <= '0;
        cmd_bus.match_mask  <= '0;
        cmd_bus.slot_flags  <= '0;
        for (n = 0; n < SLOTS; n++) begin
            slot_on[n]  = 1'b0;
            slot_hit[n] = 1'b0;
        end
        burst_left = 0;

        // Empty table, reserved opcode, then fill all slots with each pc test
        dir_rows.push_back({beat(OP_POLL, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                            1'b1, {1'b0, 3'd0, 1'b0}});
        dir_rows.push_back({beat(OP_RSVD, '1, '1, '1, '1, '1, '1, '1, '1, '1),
                            1'b1, {1'b0, 3'd0, 1'b0}});
        dir_rows.push_back({beat(OP_CHECK, '1, '1, '1, '1, '1, '1, '1, '0, '0),
                            1'b1, {1'b1, 3'd0, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '0, NO_TYPE, '0, '0, '0, '0, '0, '0, 4'b0000),
                            1'b1, {1'b1, 3'd0, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '0, '1, '1, '1, '1, '1, '1, '1, 4'b1000),
                            1'b1, {1'b1, 3'd1, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, 32'h7FFF_FFFF, NO_TYPE, '0, '0, '0, '0, '0, '0,
                                 4'b0001), 1'b1, {1'b1, 3'd2, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '0, NO_TYPE, '0, '0, '0, '0, '0, '0, 4'b0110),
                            1'b1, {1'b1, 3'd3, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '1, '1, '0, '0, '0, '0, '0, '0, 4'b0011),
                            1'b1, {1'b1, 3'd4, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, 32'h8000_0000, 7'd1, '0, '0, '0, '0, '0, '1,
                                 4'b1101), 1'b1, {1'b1, 3'd5, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, 32'h8000_0000, NO_TYPE, '0, '0, '0, '0, '0, '0,
                                 4'b0010), 1'b1, {1'b1, 3'd6, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '1, NO_TYPE, '0, '0, '0, '0, '0, '0, 4'b0111),
                            1'b1, {1'b1, 3'd7, 1'b0}});
        dir_rows.push_back({beat(OP_ADD, '1, '1, '1, '1, '1, '1, '1, '1, '1),
                            1'b1, {1'b0, 3'd0, 1'b0}});
        // Trigger, poll twice without clearing, then clear on the next check
        dir_rows.push_back({beat(OP_CHECK, '1, '1, '1, '1, '1, '1, '1, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_POLL, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_POLL, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_CHECK, 32'h8000_0000, 7'd1, '0, '0, '0, '0, '0, '0, '0),
                            1'b0, 5'd0});
        dir_rows.push_back({beat(OP_POLL, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_CHECK, 32'h8000_0001, 7'd1, '0, '0, '0, '0, '0, '0, '0),
                            1'b0, 5'd0});
        dir_rows.push_back({beat(OP_POLL, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, 5'd0});
        // Refill a freed slot with a partial mask and a signed greater-than test
        dir_rows.push_back({beat(OP_ADD, 32'hFFFF_FF00, 7'h55, 5'd10, 5'd21, 5'd3, 10'h2AA,
                                 32'hDEAD_BEEF, 57'h1F_0000_0000_7C1F, 4'b1101),
                            1'b0, 5'd0});
        dir_rows.push_back({beat(OP_CHECK, 32'hFFFF_FF01, 7'h55, 5'd10, 5'd0, 5'd3, 10'h0,
                                 32'h1234_5678, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_CHECK, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_POLL, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, 5'd0});
        dir_rows.push_back({beat(OP_RSVD, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                            1'b1, {1'b0, 3'd0, 1'b0}});

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        foreach (dir_rows[r])
            offer(dir_rows[r].beat, dir_rows[r].fixed, dir_rows[r].rsp);
        for (n = 0; n < RANDOM_BEATS; n++)
            offer(random_beat(), 1'b0, 5'd0);
        cmd_bus.valid <= 1'b0;

        // Drain outstanding responses, then allow a few spare cycles
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && rsp_due_q.size() == 0) begin
            $display("breakpoint_trigger_unit test passed");
        end else begin
            $display("breakpoint_trigger_unit test failed");
        end
        $finish;
    end

    // Response side: rotate stall patterns, with one long hold-off under load
    initial begin
        int  cyc;
        int  mode;
        logic held;
        rsp_bus.ready <= 1'b0;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!held && rsp_seen >= HOLD_AFTER) begin
                held = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
                0:       rsp_bus.ready <= 1'b1;
                1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                2:       rsp_bus.ready <= (cyc % 4 == 0);
                default: rsp_bus.ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Compare each response beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got_rsp = {rsp_bus.success, rsp_bus.slot_index, rsp_bus.slot_one_shot};
            rsp_seen++;
            if (rsp_due_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected response beat: success=%0d slot=%0d used_up=%0d",
                             got_rsp.success, got_rsp.slot_index, got_rsp.used_up);
            end else begin
                want_rsp = rsp_due_q.pop_front();
                if (got_rsp.success !== want_rsp.success
                        || got_rsp.slot_index !== want_rsp.slot_index
                        || got_rsp.used_up !== want_rsp.used_up) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("response %0d mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 rsp_seen, want_rsp.success, want_rsp.slot_index,
                                 want_rsp.used_up, got_rsp.success, got_rsp.slot_index,
                                 got_rsp.used_up);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no beat on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        fail_count  = 0;
        rsp_seen    = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("breakpoint_trigger_unit test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/btu_pkg.sv
rtl/btu_if.sv
rtl/btu_slot_match.sv
rtl/breakpoint_trigger_unit.sv
tb/tb_breakpoint_trigger_unit.sv
